// ===== design/set_assoc_lru_cache_model_unit_macros.svh =====
// Assertion macros for the set-associative LRU cache model.
// Taken in by the files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_UNIT_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slc: next-cycle check failed");

`endif

// ===== design/slc_pkg.sv =====
// Shared types and constants of the set-associative LRU cache model.
// No dependencies; every other file of the block but the macro header imports it.
package slc_pkg;

    localparam int FIELD_ADDR_W = 48;
    localparam int CNT_W        = 48;
    localparam int ST_W         = 2;

    // Line states
    localparam logic [ST_W-1:0] LS_INV = 2'd0;
    localparam logic [ST_W-1:0] LS_EXC = 2'd1;
    localparam logic [ST_W-1:0] LS_MOD = 2'd2;

    typedef logic [CNT_W-1:0] slc_count_t;

    // Outcome of one finished access, handed to the statistics counters
    typedef struct packed {
        logic valid;
        logic hit;
        logic writeback;
        logic prefetch;
    } slc_event_t;

endpackage

// ===== design/slc_req_if.sv =====
// Request channel of the cache model: one memory access per item.
// Depends on slc_pkg for the address field width.
interface slc_req_if;
    import slc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [FIELD_ADDR_W-1:0] address;
    logic                    is_write;
    logic                    prefetch;

    modport source (output valid, output address, output is_write, output prefetch,
                    input ready);
    modport sink (input valid, input address, input is_write, input prefetch,
                  output ready);
endinterface

// ===== design/slc_rsp_if.sv =====
// Response channel of the cache model: one result item per access.
// Depends on slc_pkg for field widths.
interface slc_rsp_if;
    import slc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic                    writeback;
    logic [FIELD_ADDR_W-1:0] victim_line_address;
    logic [ST_W-1:0]         line_state_after;
    logic [CNT_W-1:0]        hit_total;
    logic [CNT_W-1:0]        miss_total;
    logic [CNT_W-1:0]        writeback_total;

    modport source (output valid, output hit, output writeback, output victim_line_address,
                    output line_state_after, output hit_total, output miss_total,
                    output writeback_total, input ready);
    modport sink (input valid, input hit, input writeback, input victim_line_address,
                  input line_state_after, input hit_total, input miss_total,
                  input writeback_total, output ready);
endinterface

// ===== design/slc_way_unit.sv =====
// Shared per-way unit: tag match and LRU check for the scan, rank/state/tag update
// for the write-back pass. Depends on slc_pkg.
module slc_way_unit #(
    parameter int TAG_W  = 33,
    parameter int RANK_W = 3,
    parameter int WAYS   = 8
) (
    input  logic [TAG_W-1:0]        ent_tag,
    input  logic [slc_pkg::ST_W-1:0] ent_st,
    input  logic [RANK_W-1:0]       ent_rank,
    input  logic [TAG_W-1:0]        cmp_tag,
    input  logic [RANK_W-1:0]       touch_rank,
    input  logic                    is_target,
    input  logic [slc_pkg::ST_W-1:0] new_st,
    output logic                    tag_hit,
    output logic                    is_lru,
    output logic [TAG_W-1:0]        upd_tag,
    output logic [slc_pkg::ST_W-1:0] upd_st,
    output logic [RANK_W-1:0]       upd_rank
);
    import slc_pkg::*;

    localparam logic [RANK_W-1:0] LRU_RANK = RANK_W'(WAYS - 1);

    assign tag_hit = (ent_st != LS_INV) && (ent_tag == cmp_tag);
    assign is_lru  = (ent_rank == LRU_RANK);

    // Touched way goes to rank 0; younger ways age by one
    always_comb
    begin
        if (is_target)
        begin
            upd_rank = '0;
        end
        else if (ent_rank < touch_rank)
        begin
            upd_rank = ent_rank + RANK_W'(1);
        end
        else
        begin
            upd_rank = ent_rank;
        end
    end

    assign upd_st  = is_target ? new_st : ent_st;
    assign upd_tag = is_target ? cmp_tag : ent_tag;

endmodule

// ===== design/slc_stats.sv =====
// Demand hit, demand miss and writeback counters, wrapping at 48 bits.
// Depends on slc_pkg for the event struct and counter type.
module slc_stats (
    input  logic                clk,
    input  logic                rst_n,
    input  slc_pkg::slc_event_t ev,
    output slc_pkg::slc_count_t hit_total,
    output slc_pkg::slc_count_t miss_total,
    output slc_pkg::slc_count_t writeback_total
);
    import slc_pkg::*;

    slc_count_t hit_cnt_reg, hit_cnt_next;
    slc_count_t miss_cnt_reg, miss_cnt_next;
    slc_count_t wb_cnt_reg, wb_cnt_next;

    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        wb_cnt_next   = wb_cnt_reg;
        if (ev.valid)
        begin
            // prefetches count only towards writebacks
            if (ev.hit && !ev.prefetch)
            begin
                hit_cnt_next = hit_cnt_reg + CNT_W'(1);
            end
            if (!ev.hit && !ev.prefetch)
            begin
                miss_cnt_next = miss_cnt_reg + CNT_W'(1);
            end
            if (ev.writeback)
            begin
                wb_cnt_next = wb_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            wb_cnt_reg   <= '0;
        end
        else
        begin
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            wb_cnt_reg   <= wb_cnt_next;
        end
    end

    assign hit_total       = hit_cnt_reg;
    assign miss_total      = miss_cnt_reg;
    assign writeback_total = wb_cnt_reg;

endmodule

// ===== design/set_assoc_lru_cache_model_unit.sv =====
// Set-associative write-back cache model with true LRU, one access per request item
// and one result item per access. After reset the block sweeps its set memory once,
// one set per cycle (NUM_SETS sets, 512 by default), and takes no request meanwhile.
// An access is taken only in idle and then runs through these steps before the next:
// one set read, a scan of the ways through a single shared tag/LRU unit,
// a second pass through that unit to rebuild ranks, states and tags, and a step that
// writes the set back and loads the result register. The result register waits for
// the sink while the block returns to idle; that last step stalls for as long as
// the previous result item is still waiting. NUM_SETS and LINE_BYTES must be powers of two.
// Depends on slc_pkg, slc_req_if, slc_rsp_if, slc_way_unit, slc_stats and the macro header.
`include "set_assoc_lru_cache_model_unit_macros.svh"

module set_assoc_lru_cache_model_unit #(
    parameter int NUM_SETS     = 512,
    parameter int WAYS         = 8,
    parameter int LINE_BYTES   = 64,
    parameter int ADDRESS_BITS = 48
) (
    input  logic      clk,
    input  logic      rst_n,
    slc_req_if.sink   req,
    slc_rsp_if.source rsp
);
    import slc_pkg::*;

    localparam int ADDR_W = (ADDRESS_BITS < FIELD_ADDR_W) ? ADDRESS_BITS : FIELD_ADDR_W;
    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int SET_IW = (SET_W > 0) ? SET_W : 1;
    localparam int TAG_W  = ADDR_W - OFF_W - SET_W;
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_W = $clog2(WAYS + 1);
    localparam int CLR_W  = $clog2(NUM_SETS + 1);
    localparam int ENT_W  = TAG_W + ST_W + RANK_W;
    localparam int ROW_W  = WAYS * ENT_W;
    localparam logic [RANK_W-1:0] LRU_RANK = RANK_W'(WAYS - 1);

    // Sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CLR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [WCNT_W-1:0] way_cnt_reg, way_cnt_next;
    logic [SET_IW-1:0] set_reg, set_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic              wr_reg, wr_next;
    logic              pf_reg, pf_next;
    logic              found_vld_reg, found_vld_next;
    logic [RANK_W-1:0] found_idx_reg, found_idx_next;
    logic [RANK_W-1:0] found_rank_reg, found_rank_next;
    logic [ST_W-1:0]   found_st_reg, found_st_next;
    logic [RANK_W-1:0] vic_idx_reg, vic_idx_next;
    logic [ST_W-1:0]   vic_st_reg, vic_st_next;
    logic [TAG_W-1:0]  vic_tag_reg, vic_tag_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              rsp_vld_reg, rsp_vld_next;
    logic              rsp_hit_reg, rsp_hit_next;
    logic              rsp_wb_reg, rsp_wb_next;
    logic [FIELD_ADDR_W-1:0] rsp_vaddr_reg, rsp_vaddr_next;
    logic [ST_W-1:0]   rsp_st_reg, rsp_st_next;

    // Set memory
    logic [ROW_W-1:0]  mem [NUM_SETS];
    logic [ROW_W-1:0]  rd_q;
    logic              mem_we;
    logic              mem_re;
    logic [SET_IW-1:0] mem_wa;
    logic [ROW_W-1:0]  mem_wd;
    logic [ROW_W-1:0]  reset_row;

    logic [ADDR_W-1:0] addr_in;
    logic [ADDR_W-1:0] line_in;
    logic [RANK_W-1:0] way_idx;
    logic [ENT_W-1:0]  ent;
    logic [RANK_W-1:0] target_idx;
    logic [RANK_W-1:0] touch_rank;
    logic [ST_W-1:0]   res_st;
    logic              res_wb;
    logic [ADDR_W-1:0] vline;
    logic [ADDR_W-1:0] vaddr;
    logic              last_way;
    logic              out_free;
    logic              finish;
    slc_event_t        ev;

    logic              u_tag_hit;
    logic              u_is_lru;
    logic [TAG_W-1:0]  u_tag;
    logic [ST_W-1:0]   u_st;
    logic [RANK_W-1:0] u_rank;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            reset_row[w*ENT_W +: ENT_W] = {{TAG_W{1'b0}}, LS_INV, RANK_W'(WAYS - 1 - w)};
        end
    end

    assign addr_in = req.address[ADDR_W-1:0];
    assign line_in = addr_in >> OFF_W;

    assign way_idx  = way_cnt_reg[RANK_W-1:0];
    assign ent      = rd_q[way_idx*ENT_W +: ENT_W];
    assign last_way = (way_cnt_reg == WCNT_W'(WAYS - 1));

    assign target_idx = found_vld_reg ? found_idx_reg : vic_idx_reg;
    assign touch_rank = found_vld_reg ? found_rank_reg : LRU_RANK;
    assign res_st     = wr_reg ? LS_MOD : (found_vld_reg ? found_st_reg : LS_EXC);
    assign res_wb     = !found_vld_reg && (vic_st_reg == LS_MOD);
    assign vline      = (ADDR_W'(vic_tag_reg) << SET_W) | ADDR_W'(set_reg);
    assign vaddr      = vline << OFF_W;

    assign out_free = !rsp_vld_reg || rsp.ready;
    assign finish   = (state_reg == S_DONE) && out_free;

    slc_way_unit #(
        .TAG_W  (TAG_W),
        .RANK_W (RANK_W),
        .WAYS   (WAYS)
    ) u_way (
        .ent_tag    (ent[RANK_W+ST_W +: TAG_W]),
        .ent_st     (ent[RANK_W +: ST_W]),
        .ent_rank   (ent[RANK_W-1:0]),
        .cmp_tag    (tag_reg),
        .touch_rank (touch_rank),
        .is_target  (way_idx == target_idx),
        .new_st     (res_st),
        .tag_hit    (u_tag_hit),
        .is_lru     (u_is_lru),
        .upd_tag    (u_tag),
        .upd_st     (u_st),
        .upd_rank   (u_rank)
    );

    always_comb
    begin
        ev.valid     = finish;
        ev.hit       = found_vld_reg;
        ev.writeback = res_wb;
        ev.prefetch  = pf_reg;
    end

    slc_stats u_stats (
        .clk             (clk),
        .rst_n           (rst_n),
        .ev              (ev),
        .hit_total       (rsp.hit_total),
        .miss_total      (rsp.miss_total),
        .writeback_total (rsp.writeback_total)
    );

    assign mem_we = (state_reg == S_CLEAR) || finish;
    assign mem_re = (state_reg == S_READ);
    assign mem_wa = (state_reg == S_CLEAR) ? clr_cnt_reg[SET_IW-1:0] : set_reg;
    assign mem_wd = (state_reg == S_CLEAR) ? reset_row : row_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_q <= mem[set_reg];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        way_cnt_next    = way_cnt_reg;
        set_next        = set_reg;
        tag_next        = tag_reg;
        wr_next         = wr_reg;
        pf_next         = pf_reg;
        found_vld_next  = found_vld_reg;
        found_idx_next  = found_idx_reg;
        found_rank_next = found_rank_reg;
        found_st_next   = found_st_reg;
        vic_idx_next    = vic_idx_reg;
        vic_st_next     = vic_st_reg;
        vic_tag_next    = vic_tag_reg;
        row_next        = row_reg;
        rsp_vld_next    = rsp_vld_reg && !rsp.ready;
        rsp_hit_next    = rsp_hit_reg;
        rsp_wb_next     = rsp_wb_reg;
        rsp_vaddr_next  = rsp_vaddr_reg;
        rsp_st_next     = rsp_st_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                if (clr_cnt_reg == CLR_W'(NUM_SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    set_next   = SET_IW'(line_in % NUM_SETS);
                    tag_next   = TAG_W'(line_in / NUM_SETS);
                    wr_next    = req.is_write;
                    pf_next    = req.prefetch;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                found_vld_next = 1'b0;
                vic_idx_next   = '0;
                way_cnt_next   = '0;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                // first matching way wins; the LRU way is unique
                if (u_tag_hit && !found_vld_reg)
                begin
                    found_vld_next  = 1'b1;
                    found_idx_next  = way_idx;
                    found_rank_next = ent[RANK_W-1:0];
                    found_st_next   = ent[RANK_W +: ST_W];
                end
                if (u_is_lru)
                begin
                    vic_idx_next = way_idx;
                    vic_st_next  = ent[RANK_W +: ST_W];
                    vic_tag_next = ent[RANK_W+ST_W +: TAG_W];
                end
                way_cnt_next = last_way ? '0 : way_cnt_reg + WCNT_W'(1);
                if (last_way)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                row_next[way_idx*ENT_W +: ENT_W] = {u_tag, u_st, u_rank};
                way_cnt_next = last_way ? '0 : way_cnt_reg + WCNT_W'(1);
                if (last_way)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (out_free)
                begin
                    rsp_vld_next   = 1'b1;
                    rsp_hit_next   = found_vld_reg;
                    rsp_wb_next    = res_wb;
                    rsp_vaddr_next = res_wb ? FIELD_ADDR_W'(vaddr) : '0;
                    rsp_st_next    = res_st;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            way_cnt_reg   <= '0;
            found_vld_reg <= 1'b0;
            rsp_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            way_cnt_reg   <= way_cnt_next;
            found_vld_reg <= found_vld_next;
            rsp_vld_reg   <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg        <= set_next;
        tag_reg        <= tag_next;
        wr_reg         <= wr_next;
        pf_reg         <= pf_next;
        found_idx_reg  <= found_idx_next;
        found_rank_reg <= found_rank_next;
        found_st_reg   <= found_st_next;
        vic_idx_reg    <= vic_idx_next;
        vic_st_reg     <= vic_st_next;
        vic_tag_reg    <= vic_tag_next;
        row_reg        <= row_next;
        rsp_hit_reg    <= rsp_hit_next;
        rsp_wb_reg     <= rsp_wb_next;
        rsp_vaddr_reg  <= rsp_vaddr_next;
        rsp_st_reg     <= rsp_st_next;
    end

    assign req.ready               = (state_reg == S_IDLE);
    assign rsp.valid               = rsp_vld_reg;
    assign rsp.hit                 = rsp_hit_reg;
    assign rsp.writeback           = rsp_wb_reg;
    assign rsp.victim_line_address = rsp_vaddr_reg;
    assign rsp.line_state_after    = rsp_st_reg;

    `SLC_ASSERT_IMPLIES(a_wb_only_on_miss, rsp.valid && rsp.writeback, !rsp.hit)
    `SLC_ASSERT_IMPLIES(a_victim_zero_no_wb, rsp.valid && !rsp.writeback, rsp_vaddr_reg == '0)
    `SLC_ASSERT_IMPLIES(a_state_live, rsp.valid, rsp_st_reg == LS_EXC || rsp_st_reg == LS_MOD)
    `SLC_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)

endmodule

// ===== bench/set_assoc_lru_cache_model_unit_test.sv =====
// Self-checking bench for the 8-way write-back LRU cache model: access items in,
// one outcome item back per access, checked against a mirror of tags, states and ranks.
// Depends on slc_pkg, slc_req_if, slc_rsp_if and set_assoc_lru_cache_model_unit.
`timescale 1ns / 1ps

module set_assoc_lru_cache_model_unit_test;
    import slc_pkg::*;

    localparam int NUM_SETS     = 512;
    localparam int WAYS         = 8;
    localparam int TAG_W        = 33;
    localparam int SET_W        = 9;
    localparam int OFS_W        = 6;
    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_ITEMS   = 60;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 150000;

    typedef struct packed {
        logic                    hit;
        logic                    writeback;
        logic [FIELD_ADDR_W-1:0] victim_line_address;
        logic [ST_W-1:0]         line_state_after;
        logic [CNT_W-1:0]        hit_total;
        logic [CNT_W-1:0]        miss_total;
        logic [CNT_W-1:0]        writeback_total;
    } access_outcome_t;

    // Mirror of the cache contents; works out the outcome of each accepted access
    class lru_cache_mirror;
        logic [TAG_W-1:0] tags [NUM_SETS*WAYS];
        logic [ST_W-1:0]  line_st [NUM_SETS*WAYS];
        int unsigned      rank [NUM_SETS*WAYS];
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] writebacks;
        access_outcome_t  expected_outcomes[$];
        int               errors;

        function new();
            for (int i = 0; i < NUM_SETS * WAYS; i++)
            begin
                tags[i]    = '0;
                line_st[i] = LS_INV;
                rank[i]    = WAYS - 1 - (i % WAYS);
            end
            hits       = '0;
            misses     = '0;
            writebacks = '0;
            errors     = 0;
        endfunction

        // Age every way younger than w by one, then make w the youngest
        function void make_most_recent(int base, int w);
            int unsigned r;
            r = rank[base + w];
            for (int k = 0; k < WAYS; k++)
                if (rank[base + k] < r)
                    rank[base + k]++;
            rank[base + w] = 0;
        endfunction

        function void note_access(logic [FIELD_ADDR_W-1:0] addr, logic wr, logic pf);
            logic [TAG_W-1:0] tag;
            logic [SET_W-1:0] set_idx;
            int               base;
            int               found;
            int               victim;
            access_outcome_t  outcome;
            tag     = addr[FIELD_ADDR_W-1 -: TAG_W];
            set_idx = addr[OFS_W +: SET_W];
            base    = int'(set_idx) * WAYS;
            found   = -1;
            victim  = 0;
            outcome = '0;
            for (int w = 0; w < WAYS; w++)
                if (found < 0 && line_st[base + w] != LS_INV && tags[base + w] == tag)
                    found = w;
            if (found >= 0)
            begin
                outcome.hit = 1'b1;
                if (wr)
                    line_st[base + found] = LS_MOD;
                outcome.line_state_after = line_st[base + found];
                make_most_recent(base, found);
                if (!pf)
                    hits++;
            end
            else
            begin
                for (int w = 0; w < WAYS; w++)
                    if (rank[base + w] == WAYS - 1)
                        victim = w;
                // an invalid or clean victim goes silently
                if (line_st[base + victim] == LS_MOD)
                begin
                    outcome.writeback           = 1'b1;
                    outcome.victim_line_address = {tags[base + victim], set_idx, {OFS_W{1'b0}}};
                    writebacks++;
                end
                outcome.line_state_after = wr ? LS_MOD : LS_EXC;
                tags[base + victim]      = tag;
                line_st[base + victim]   = outcome.line_state_after;
                make_most_recent(base, victim);
                if (!pf)
                    misses++;
            end
            outcome.hit_total       = hits;
            outcome.miss_total      = misses;
            outcome.writeback_total = writebacks;
            expected_outcomes.insert(expected_outcomes.size(), outcome);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_outcome(access_outcome_t got);
            access_outcome_t want;
            if (expected_outcomes.size() == 0)
            begin
                $error("outcome item with no access pending");
                errors++;
                return;
            end
            want = expected_outcomes[0];
            expected_outcomes.delete(0);
            compare_field("hit", 64'(want.hit), 64'(got.hit));
            compare_field("writeback", 64'(want.writeback), 64'(got.writeback));
            compare_field("victim_line_address", 64'(want.victim_line_address),
                          64'(got.victim_line_address));
            compare_field("line_state_after", 64'(want.line_state_after),
                          64'(got.line_state_after));
            compare_field("hit_total", 64'(want.hit_total), 64'(got.hit_total));
            compare_field("miss_total", 64'(want.miss_total), 64'(got.miss_total));
            compare_field("writeback_total", 64'(want.writeback_total),
                          64'(got.writeback_total));
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            tail_calm;
    int              cycle_count;
    lru_cache_mirror mirror;

    slc_req_if req_ch();
    slc_rsp_if rsp_ch();

    set_assoc_lru_cache_model_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Outcome sink: ready drops in bursts except in the calm tail
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0 && !tail_calm)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!tail_calm && $urandom_range(0, 5) == 0)
            begin
                stall_left   = $urandom_range(1, 11) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            mirror.check_outcome('{rsp_ch.hit, rsp_ch.writeback, rsp_ch.victim_line_address,
                                   rsp_ch.line_state_after, rsp_ch.hit_total,
                                   rsp_ch.miss_total, rsp_ch.writeback_total});

    // Offer one access, with an occasional idle burst first; return once accepted
    task automatic send_access(logic [FIELD_ADDR_W-1:0] addr, logic wr, logic pf);
        int gap;
        if (!tail_calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.address  <= addr;
        req_ch.is_write <= wr;
        req_ch.prefetch <= pf;
        do
            @(posedge clk);
        while (!req_ch.ready);
        mirror.note_access(addr, wr, pf);
    endtask

    function automatic logic [TAG_W-1:0] pick_tag();
        // a small pool per set forces both hits and evictions
        if ($urandom_range(0, 15) == 0)
            return {TAG_W{1'b1}} - TAG_W'($urandom_range(0, 1));
        return TAG_W'($urandom_range(0, 10));
    endfunction

    initial
    begin
        logic [SET_W-1:0]        hot_sets [4];
        logic [63:0]             wide;
        logic [FIELD_ADDR_W-1:0] addr;
        mirror          = new();
        cycle_count     = 0;
        tail_calm       = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.address  = '0;
        req_ch.is_write = 1'b0;
        req_ch.prefetch = 1'b0;
        hot_sets[0] = '0;
        hot_sets[1] = '1;
        hot_sets[2] = SET_W'(170);
        hot_sets[3] = SET_W'($urandom);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // miss into an invalid way, read hit, write hit, read hit on a modified line, write miss, prefetch hit
        send_access('0, 1'b0, 1'b0);
        send_access(FIELD_ADDR_W'(63), 1'b0, 1'b0);
        send_access('0, 1'b1, 1'b0);
        send_access('0, 1'b0, 1'b0);
        send_access('1, 1'b1, 1'b0);
        send_access({{(FIELD_ADDR_W-OFS_W){1'b1}}, {OFS_W{1'b0}}}, 1'b0, 1'b1);
        // fill set 0 with dirty lines, then evict them; last one as a prefetch
        for (int t = 1; t <= 9; t++)
            send_access({TAG_W'(t), {SET_W{1'b0}}, {OFS_W{1'b0}}}, 1'b1, t == 9);
        send_access({{TAG_W{1'b1}}, {SET_W{1'b0}}, {OFS_W{1'b0}}}, 1'b1, 1'b1);
        for (int t = 10; t <= 17; t++)
            send_access({TAG_W'(t), {SET_W{1'b0}}, OFS_W'($urandom)}, 1'b0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                tail_calm = 1'b1;
            if ($urandom_range(0, 9) == 0)
            begin
                wide = {$urandom, $urandom};
                addr = wide[FIELD_ADDR_W-1:0];
            end
            else
                addr = {pick_tag(), hot_sets[$urandom_range(0, 3)], OFS_W'($urandom)};
            send_access(addr, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
        end
        @(negedge clk);
        req_ch.valid <= 1'b0;

        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
